// ===== hdl/vpa_pkg.sv =====
`timescale 1ns / 1ps
package vpa_pkg;

  localparam int MAX_SEGMENTS_DEF = 32;
  localparam int QUEUE_DEPTH_DEF  = 8;
  localparam logic [15:0] MEM_SIZE_RESET = 16'd1024;

  localparam logic [0:0] REG_MEMORY_SIZE = 1'b0;
  localparam logic [0:0] REG_FIT_POLICY  = 1'b1;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_FREED     = 3'd1,
    ST_QUEUED    = 3'd2,
    ST_DROPPED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_TOO_LARGE = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SCAN1, S_PLACE1, S_CMP, S_SCAN2, S_PLACE2,
    S_FSCAN, S_FREE_B, S_FREE_C, S_QLOAD, S_QSCAN, S_QPLACE, S_EMIT_F, S_EMIT_Q
  } state_t;

  typedef struct packed {
    logic    load;
    logic    scan_init;
    logic    scan_step;
    logic    fscan_step;
    logic    place;
    logic    cmp_init;
    logic    cmp_step;
    logic    cmp_end;
    logic    free_a;
    logic    free_b;
    logic    free_c;
    logic    q_load;
    logic    q_push;
    logic    q_pop;
    logic    emit_alloc;
    logic    emit_code;
    logic    emit_free;
    logic    emit_q;
    status_t code;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic too_large;
    logic scan_done;
    logic found;
    logic place_ok;
    logic q_has;
    logic q_full;
    logic qok;
  } sts_t;

endpackage

// ===== hdl/vpa_ctrl.sv =====
`timescale 1ns / 1ps
module vpa_ctrl import vpa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.code = ST_ALLOCATED;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.scan_init = 1'b1;
        if (sts.is_free) begin
          state_next = S_FSCAN;
        end else if (sts.too_large) begin
          cmd.emit_code = 1'b1;
          cmd.code = ST_TOO_LARGE;
          state_next = S_IDLE;
        end else begin
          state_next = S_SCAN1;
        end
      end
      S_SCAN1: begin
        if (sts.scan_done) state_next = S_PLACE1;
        else cmd.scan_step = 1'b1;
      end
      S_PLACE1: begin
        cmd.place = 1'b1;
        if (sts.place_ok) begin
          cmd.emit_alloc = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.cmp_init = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        // scan_done here only means the index ran past the table
        if (sts.scan_done) begin
          cmd.cmp_end = 1'b1;
          cmd.scan_init = 1'b1;
          state_next = S_SCAN2;
        end else begin
          cmd.cmp_step = 1'b1;
        end
      end
      S_SCAN2: begin
        if (sts.scan_done) state_next = S_PLACE2;
        else cmd.scan_step = 1'b1;
      end
      S_PLACE2: begin
        cmd.place = 1'b1;
        state_next = S_IDLE;
        if (sts.place_ok) begin
          cmd.emit_alloc = 1'b1;
        end else if (!sts.q_full) begin
          cmd.q_push = 1'b1;
          cmd.emit_code = 1'b1;
          cmd.code = ST_QUEUED;
        end else begin
          cmd.emit_code = 1'b1;
          cmd.code = ST_DROPPED;
        end
      end
      S_FSCAN: begin
        if (sts.scan_done) begin
          if (sts.found) begin
            cmd.free_a = 1'b1;
            state_next = S_FREE_B;
          end else begin
            cmd.emit_code = 1'b1;
            cmd.code = ST_NOT_FOUND;
            state_next = S_IDLE;
          end
        end else begin
          cmd.fscan_step = 1'b1;
        end
      end
      S_FREE_B: begin
        cmd.free_b = 1'b1;
        state_next = S_FREE_C;
      end
      S_FREE_C: begin
        cmd.free_c = 1'b1;
        state_next = sts.q_has ? S_QLOAD : S_EMIT_F;
      end
      S_QLOAD: begin
        cmd.q_load = 1'b1;
        cmd.scan_init = 1'b1;
        state_next = S_QSCAN;
      end
      S_QSCAN: begin
        if (sts.scan_done) state_next = S_QPLACE;
        else cmd.scan_step = 1'b1;
      end
      S_QPLACE: begin
        cmd.place = 1'b1;
        if (sts.place_ok) cmd.q_pop = 1'b1;
        state_next = S_EMIT_F;
      end
      S_EMIT_F: begin
        cmd.emit_free = 1'b1;
        state_next = sts.qok ? S_EMIT_Q : S_IDLE;
      end
      S_EMIT_Q: begin
        cmd.emit_q = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hdl/vpa_dp.sv =====
`timescale 1ns / 1ps
module vpa_dp import vpa_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        opcode,
  input  logic [15:0] req_size,
  input  logic        wr_en,
  input  logic [0:0]  wr_index,
  input  logic [15:0] wr_data,
  output logic        done,
  output logic [2:0]  status,
  output logic [15:0] region_start,
  output logic [15:0] region_size,
  output logic        from_queue,
  output logic        compacted,
  output logic [15:0] compaction_total,
  output logic        last
);

  localparam int IW  = $clog2(MAX_SEGMENTS);
  localparam int CW  = $clog2(MAX_SEGMENTS + 1);
  localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] SEG_MAX = CW'(MAX_SEGMENTS);
  localparam logic [QCW:0]  QD_EXT  = (QCW + 1)'(QUEUE_DEPTH);
  localparam logic [QCW-1:0] QD_CNT = QCW'(QUEUE_DEPTH);

  logic [15:0]           len [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] used;
  logic [CW-1:0]         cnt;
  logic [15:0]           q [QUEUE_DEPTH];
  logic [QW-1:0]         qhead;
  logic [QCW-1:0]        qcnt;
  logic [15:0]           ccount;
  logic [15:0]           memsize;
  logic [1:0]            policy;

  logic                  op;
  logic [15:0]           req, cur_size;
  logic [CW-1:0]         k, n, pick;
  logic [15:0]           acc, pick_len, pick_start, free_start, tot;
  logic [1:0]            nfree;
  logic                  found, stop, comp, qok;

  logic [IW-1:0]  idx, pick_idx, n_idx;
  logic [15:0]    lk;
  logic           uk, k_in, cand, better, first_like, split, place_ok;
  logic [CW-1:0]  n_fin;
  logic [QCW:0]   tsum;
  logic [QW-1:0]  tail, head_inc;

  assign idx      = k[IW-1:0];
  assign pick_idx = pick[IW-1:0];
  assign n_idx    = n[IW-1:0];
  assign lk       = len[idx];
  assign uk       = used[idx];
  assign k_in     = (k < cnt);
  assign first_like = (policy != FIT_BEST) && (policy != FIT_WORST);
  assign cand     = k_in && !uk && (lk >= cur_size);
  assign better   = !found || ((policy == FIT_BEST) && (lk < pick_len)) ||
                    ((policy == FIT_WORST) && (lk > pick_len));
  assign split    = (pick_len != cur_size);
  assign place_ok = found && (!split || (cnt < SEG_MAX));
  // free space lands in one tail segment when there is any
  assign n_fin    = ((nfree != 2'd0) && (n < SEG_MAX)) ? n + 1'b1 : n;

  assign tsum     = (QCW + 1)'(qhead) + (QCW + 1)'(qcnt);
  assign tail     = (tsum >= QD_EXT) ? QW'(tsum - QD_EXT) : QW'(tsum);
  assign head_inc = ((QCW + 1)'(qhead) + 1'b1 >= QD_EXT) ? '0 : qhead + 1'b1;

  always_comb begin
    sts.is_free   = (op == OP_FREE);
    sts.too_large = (req == 16'd0) || (req > memsize);
    sts.scan_done = !k_in || stop;
    sts.found     = found;
    sts.place_ok  = place_ok;
    sts.q_has     = (qcnt != '0);
    sts.q_full    = (qcnt == QD_CNT);
    sts.qok       = qok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= '0;
      cnt     <= CW'(1);
      len[0]  <= MEM_SIZE_RESET;
      memsize <= MEM_SIZE_RESET;
      policy  <= FIT_FIRST;
      qhead   <= '0;
      qcnt    <= '0;
      ccount  <= '0;
      done    <= 1'b0;
    end else begin
      done <= cmd.emit_alloc | cmd.emit_code | cmd.emit_free | cmd.emit_q;

      if (wr_en) begin
        if (wr_index == REG_MEMORY_SIZE) begin
          memsize <= wr_data;
          len[0]  <= wr_data;
          used    <= '0;
          cnt     <= CW'(1);
          qhead   <= '0;
          qcnt    <= '0;
        end else begin
          policy <= wr_data[1:0];
        end
      end

      if (cmd.load) begin
        op       <= opcode;
        req      <= req_size;
        cur_size <= req_size;
        comp     <= 1'b0;
        qok      <= 1'b0;
      end

      if (cmd.scan_init) begin
        k     <= '0;
        acc   <= '0;
        found <= 1'b0;
        stop  <= 1'b0;
      end

      if (cmd.scan_step) begin
        if (cand && better) begin
          found      <= 1'b1;
          pick       <= k;
          pick_len   <= lk;
          pick_start <= acc;
          if (first_like) stop <= 1'b1;
        end
        k   <= k + 1'b1;
        acc <= acc + lk;
      end

      if (cmd.fscan_step) begin
        if (k_in && uk && (lk == req)) begin
          found      <= 1'b1;
          pick       <= k;
          pick_start <= acc;
          stop       <= 1'b1;
        end
        k   <= k + 1'b1;
        acc <= acc + lk;
      end

      if (cmd.place && place_ok) begin
        if (split) begin
          for (int j = 1; j < MAX_SEGMENTS; j++) begin
            if ((CW'(j) > pick + 1'b1) && (CW'(j) <= cnt)) begin
              len[j]  <= len[j-1];
              used[j] <= used[j-1];
            end
            if (CW'(j) == pick + 1'b1) begin
              len[j]  <= pick_len - cur_size;
              used[j] <= 1'b0;
            end
          end
          cnt <= cnt + 1'b1;
        end
        len[pick_idx]  <= cur_size;
        used[pick_idx] <= 1'b1;
      end

      if (cmd.cmp_init) begin
        k     <= '0;
        n     <= '0;
        nfree <= 2'd0;
        tot   <= '0;
        stop  <= 1'b0;
      end

      if (cmd.cmp_step) begin
        if (uk) begin
          len[n_idx]  <= lk;
          used[n_idx] <= 1'b1;
          n <= n + 1'b1;
        end else begin
          if (nfree != 2'd2) nfree <= nfree + 1'b1;
          tot <= tot + lk;
        end
        k <= k + 1'b1;
      end

      if (cmd.cmp_end) begin
        if ((nfree != 2'd0) && (n < SEG_MAX)) begin
          len[n_idx]  <= tot;
          used[n_idx] <= 1'b0;
        end
        cnt <= n_fin;
        if ((n_fin > CW'(1)) && (nfree == 2'd2)) begin
          comp <= 1'b1;
          if (ccount != 16'hFFFF) ccount <= ccount + 1'b1;
        end
      end

      if (cmd.free_a) begin
        used[pick_idx] <= 1'b0;
        free_start     <= pick_start;
        pick_len       <= req;
        k              <= pick + 1'b1;
      end

      // merge with the free segment above, then the one below
      if (cmd.free_b) begin
        if (k_in && !uk) begin
          len[pick_idx] <= pick_len + lk;
          pick_len      <= pick_len + lk;
          for (int j = 0; j < MAX_SEGMENTS - 1; j++) begin
            if ((CW'(j) >= pick + 1'b1) && (CW'(j + 1) < cnt)) begin
              len[j]  <= len[j+1];
              used[j] <= used[j+1];
            end
          end
          cnt <= cnt - 1'b1;
        end
        k <= pick - 1'b1;
      end

      if (cmd.free_c) begin
        if ((pick != '0) && !uk) begin
          len[idx] <= lk + pick_len;
          for (int j = 0; j < MAX_SEGMENTS - 1; j++) begin
            if ((CW'(j) >= pick) && (CW'(j + 1) < cnt)) begin
              len[j]  <= len[j+1];
              used[j] <= used[j+1];
            end
          end
          cnt <= cnt - 1'b1;
        end
      end

      if (cmd.q_load) cur_size <= q[qhead];

      if (cmd.q_push) begin
        q[tail] <= cur_size;
        qcnt    <= qcnt + 1'b1;
      end

      if (cmd.q_pop) begin
        qhead <= head_inc;
        qcnt  <= qcnt - 1'b1;
        qok   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    compaction_total <= ccount;
    if (cmd.emit_alloc) begin
      status       <= ST_ALLOCATED;
      region_start <= pick_start;
      region_size  <= cur_size;
      from_queue   <= 1'b0;
      compacted    <= comp;
      last         <= 1'b1;
    end else if (cmd.emit_code) begin
      status       <= cmd.code;
      region_start <= '0;
      region_size  <= cur_size;
      from_queue   <= 1'b0;
      compacted    <= comp;
      last         <= 1'b1;
    end else if (cmd.emit_free) begin
      status       <= ST_FREED;
      region_start <= free_start;
      region_size  <= req;
      from_queue   <= 1'b0;
      compacted    <= 1'b0;
      last         <= !qok;
    end else if (cmd.emit_q) begin
      status       <= ST_ALLOCATED;
      region_start <= pick_start;
      region_size  <= cur_size;
      from_queue   <= 1'b1;
      compacted    <= 1'b0;
      last         <= 1'b1;
    end
  end

endmodule

// ===== hdl/variable_partition_allocator.sv =====
`timescale 1ns / 1ps
// Segment allocator over a table of up to MAX_SEGMENTS contiguous segments.
// A request is taken when start is high and busy is low; busy stays high until
// its results have been issued. Each result is shown for one cycle with done
// high, and the receiver cannot stall it; a free that serves a waiting request
// gives two results in back-to-back cycles, the second flagged from_queue.
// Time per request is set by one-entry-per-cycle walks over the segment table:
// an allocation walks it once, or three times when it compacts (a scan, the
// compaction and a rescan); a free walks it once, and once more when the queue
// head is retried.
// Configuration writes are taken at any edge with wr_en high; the user must
// make them only while busy is low, as the block itself does not enforce it;
// writing memory_size resets the table and empties the queue.
module variable_partition_allocator import vpa_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [15:0] req_size,
  input  logic        wr_en,
  input  logic [0:0]  wr_index,
  input  logic [15:0] wr_data,
  output logic        done,
  output logic [2:0]  status,
  output logic [15:0] region_start,
  output logic [15:0] region_size,
  output logic        from_queue,
  output logic        compacted,
  output logic [15:0] compaction_total,
  output logic        last
);

  cmd_t cmd;
  sts_t sts;

  vpa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  vpa_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .QUEUE_DEPTH  (QUEUE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .opcode           (opcode),
    .req_size         (req_size),
    .wr_en            (wr_en),
    .wr_index         (wr_index),
    .wr_data          (wr_data),
    .done             (done),
    .status           (status),
    .region_start     (region_start),
    .region_size      (region_size),
    .from_queue       (from_queue),
    .compacted        (compacted),
    .compaction_total (compaction_total),
    .last             (last)
  );

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted beat did not raise busy");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_QUEUED || status == ST_DROPPED ||
             status == ST_NOT_FOUND || status == ST_TOO_LARGE) |-> last)
    else $error("single-result status without last");

  a_queue_result: assert property (@(posedge clk) disable iff (rst)
    done && from_queue |-> last && status == ST_ALLOCATED)
    else $error("queue service result malformed");

  a_pair: assert property (@(posedge clk) disable iff (rst)
    done && !last |-> status == ST_FREED ##1 done && from_queue)
    else $error("free result not followed by queue service");
`endif

endmodule

// ===== tb/tb_variable_partition_allocator.sv =====
`timescale 1ns / 1ps
module tb_variable_partition_allocator;
  import vpa_pkg::*;

  localparam int NSEG = MAX_SEGMENTS_DEF;
  localparam int QDEPTH = QUEUE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] region_start;
    logic [15:0] region_size;
    logic        from_queue;
    logic        compacted;
    logic [15:0] compaction_total;
    logic        last;
  } region_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        opcode = OP_ALLOC;
  logic [15:0] req_size = 16'd0;
  logic        wr_en = 1'b0;
  logic [0:0]  wr_index = REG_MEMORY_SIZE;
  logic [15:0] wr_data = 16'd0;
  logic        done;
  logic [2:0]  status;
  logic [15:0] region_start;
  logic [15:0] region_size;
  logic        from_queue;
  logic        compacted;
  logic [15:0] compaction_total;
  logic        last;

  // allocator image kept by the testbench
  int seg_len [NSEG];
  bit seg_used [NSEG];
  int seg_cnt;
  int wait_size [QDEPTH];
  int wait_head;
  int wait_cnt;
  int comp_cnt;
  int mem_units;
  int policy;

  region_result_t pending_results[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int cycles = 0;
  int idle_pct = 0;

  variable_partition_allocator u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .req_size(req_size), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .done(done), .status(status), .region_start(region_start),
    .region_size(region_size), .from_queue(from_queue), .compacted(compacted),
    .compaction_total(compaction_total), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("tb_variable_partition_allocator NOT OK");
      $finish;
    end
  end

  function automatic void table_init();
    for (int k = 0; k < NSEG; k++) begin
      seg_len[k] = 0;
      seg_used[k] = 1'b0;
    end
    seg_len[0] = mem_units;
    seg_cnt = 1;
    wait_head = 0;
    wait_cnt = 0;
  endfunction

  function automatic int addr_of(int idx);
    int s;
    s = 0;
    for (int k = 0; k < idx; k++) s += seg_len[k];
    return s & 16'hFFFF;
  endfunction

  function automatic bit place_region(int sz, output int st);
    int pick;
    int len;
    bit found;
    pick = 0;
    found = 1'b0;
    st = 0;
    for (int k = 0; k < seg_cnt; k++) begin
      if (seg_used[k] || seg_len[k] < sz) continue;
      if (!found) begin
        found = 1'b1;
        pick = k;
        if (policy != FIT_BEST && policy != FIT_WORST) break;
      end else if (policy == FIT_BEST && seg_len[k] < seg_len[pick]) begin
        pick = k;
      end else if (policy == FIT_WORST && seg_len[k] > seg_len[pick]) begin
        pick = k;
      end
    end
    if (!found) return 1'b0;
    len = seg_len[pick];
    if (len != sz) begin
      if (seg_cnt >= NSEG) return 1'b0;
      for (int k = seg_cnt; k > pick + 1; k--) begin
        seg_len[k] = seg_len[k-1];
        seg_used[k] = seg_used[k-1];
      end
      seg_len[pick+1] = len - sz;
      seg_used[pick+1] = 1'b0;
      seg_cnt++;
    end
    seg_len[pick] = sz;
    seg_used[pick] = 1'b1;
    st = addr_of(pick);
    return 1'b1;
  endfunction

  function automatic bit pack_table();
    int n;
    int nfree;
    int total;
    n = 0;
    nfree = 0;
    total = 0;
    for (int k = 0; k < seg_cnt; k++) begin
      if (seg_used[k]) begin
        seg_len[n] = seg_len[k];
        seg_used[n] = 1'b1;
        n++;
      end else begin
        nfree++;
        total += seg_len[k];
      end
    end
    if (nfree > 0 && n < NSEG) begin
      seg_len[n] = total & 16'hFFFF;
      seg_used[n] = 1'b0;
      n++;
    end
    seg_cnt = n;
    if (n > 1 && nfree >= 2) begin
      if (comp_cnt < 16'hFFFF) comp_cnt++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void drop_entry(int idx);
    for (int k = idx; k + 1 < seg_cnt; k++) begin
      seg_len[k] = seg_len[k+1];
      seg_used[k] = seg_used[k+1];
    end
    seg_cnt--;
  endfunction

  function automatic region_result_t mk_result(status_t st, int a, int sz, bit fq,
                                               bit cp);
    region_result_t r;
    r.status = st;
    r.region_start = a[15:0];
    r.region_size = sz[15:0];
    r.from_queue = fq;
    r.compacted = cp;
    r.compaction_total = comp_cnt[15:0];
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void predict_request(logic op, int sz);
    int a;
    int k;
    int w;
    bit cp;
    region_result_t first;
    a = 0;
    if (op == OP_ALLOC) begin
      if (sz == 0 || sz > mem_units) begin
        pending_results.push_back(mk_result(ST_TOO_LARGE, 0, sz, 0, 0));
      end else if (place_region(sz, a)) begin
        pending_results.push_back(mk_result(ST_ALLOCATED, a, sz, 0, 0));
      end else begin
        cp = pack_table();
        if (place_region(sz, a)) begin
          pending_results.push_back(mk_result(ST_ALLOCATED, a, sz, 0, cp));
        end else if (wait_cnt < QDEPTH) begin
          wait_size[(wait_head + wait_cnt) % QDEPTH] = sz;
          wait_cnt++;
          pending_results.push_back(mk_result(ST_QUEUED, 0, sz, 0, cp));
        end else begin
          pending_results.push_back(mk_result(ST_DROPPED, 0, sz, 0, cp));
        end
      end
      return;
    end
    for (k = 0; k < seg_cnt; k++)
      if (seg_used[k] && seg_len[k] == sz) break;
    if (k >= seg_cnt) begin
      pending_results.push_back(mk_result(ST_NOT_FOUND, 0, sz, 0, 0));
      return;
    end
    a = addr_of(k);
    seg_used[k] = 1'b0;
    if (k + 1 < seg_cnt && !seg_used[k+1]) begin
      seg_len[k] = (seg_len[k] + seg_len[k+1]) & 16'hFFFF;
      drop_entry(k + 1);
    end
    if (k > 0 && !seg_used[k-1]) begin
      seg_len[k-1] = (seg_len[k-1] + seg_len[k]) & 16'hFFFF;
      drop_entry(k);
    end
    first = mk_result(ST_FREED, a, sz, 0, 0);
    if (wait_cnt > 0) begin
      w = wait_size[wait_head];
      if (place_region(w, a)) begin
        wait_head = (wait_head + 1) % QDEPTH;
        wait_cnt--;
        first.last = 1'b0;
        pending_results.push_back(first);
        pending_results.push_back(mk_result(ST_ALLOCATED, a, w, 1, 0));
        return;
      end
    end
    pending_results.push_back(first);
  endfunction

  // result checker
  always @(posedge clk) begin
    region_result_t got;
    region_result_t want;
    if (!rst && done) begin
      got = '{status, region_start, region_size, from_queue, compacted,
              compaction_total, last};
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result st=%0d start=%0d size=%0d", $time,
                 got.status, got.region_start, got.region_size);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch expected st=%0d start=%0d size=%0d fq=%0b cp=%0b tot=%0d last=%0b",
                   $time, want.status, want.region_start, want.region_size,
                   want.from_queue, want.compacted, want.compaction_total, want.last);
          $display("%0t:          actual st=%0d start=%0d size=%0d fq=%0b cp=%0b tot=%0d last=%0b",
                   $time, got.status, got.region_start, got.region_size,
                   got.from_queue, got.compacted, got.compaction_total, got.last);
        end
      end
    end
  end

  task automatic send_request(logic op, int sz);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
      repeat ($urandom_range(1, 8)) @(negedge clk);
    start = 1'b1;
    opcode = op;
    req_size = sz[15:0];
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predict_request(op, sz & 16'hFFFF);
    items_sent++;
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic write_reg(logic [0:0] idx, int value);
    while (pending_results.size() != 0 || busy) @(negedge clk);
    repeat (3) @(negedge clk);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = value[15:0];
    @(negedge clk);
    wr_en = 1'b0;
    if (idx == REG_MEMORY_SIZE) begin
      mem_units = value & 16'hFFFF;
      table_init();
    end else begin
      policy = value & 3;
    end
  endtask

  function automatic int used_size_pick();
    int sizes[$];
    for (int k = 0; k < seg_cnt; k++)
      if (seg_used[k]) sizes.push_back(seg_len[k]);
    if (sizes.size() == 0) return -1;
    return sizes[$urandom_range(0, sizes.size() - 1)];
  endfunction

  task automatic test_basic();
    write_reg(REG_FIT_POLICY, FIT_FIRST);
    send_request(OP_ALLOC, 0);
    send_request(OP_ALLOC, 1025);
    send_request(OP_ALLOC, 16'hFFFF);
    send_request(OP_FREE, 7);
    send_request(OP_ALLOC, 1);
    send_request(OP_ALLOC, 500);
    send_request(OP_ALLOC, 523);
    send_request(OP_ALLOC, 600);
    send_request(OP_FREE, 1);
    send_request(OP_FREE, 500);
    send_request(OP_FREE, 523);
    send_request(OP_FREE, 600);
    send_request(OP_ALLOC, 1024);
    send_request(OP_FREE, 1024);
  endtask

  // fill the table with unit regions so the next split has no room
  task automatic test_full_table();
    write_reg(REG_MEMORY_SIZE, 64);
    for (int i = 0; i < NSEG - 1; i++) send_request(OP_ALLOC, 1);
    send_request(OP_ALLOC, 1);
    send_request(OP_ALLOC, 33);
    send_request(OP_FREE, 1);
    send_request(OP_FREE, 1);
  endtask

  task automatic test_policies();
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_MEMORY_SIZE, 100);
      write_reg(REG_FIT_POLICY, p);
      send_request(OP_ALLOC, 10);
      send_request(OP_ALLOC, 5);
      send_request(OP_ALLOC, 30);
      send_request(OP_ALLOC, 5);
      send_request(OP_FREE, 10);
      send_request(OP_FREE, 30);
      send_request(OP_ALLOC, 8);
      send_request(OP_ALLOC, 52);
    end
  endtask

  task automatic test_memory_extremes();
    write_reg(REG_MEMORY_SIZE, 1);
    send_request(OP_ALLOC, 2);
    send_request(OP_ALLOC, 1);
    send_request(OP_ALLOC, 1);
    send_request(OP_FREE, 1);
    write_reg(REG_MEMORY_SIZE, 16'hFFFF);
    send_request(OP_ALLOC, 16'h8000);
    send_request(OP_ALLOC, 16'h7FFF);
    send_request(OP_FREE, 16'h8000);
    send_request(OP_FREE, 16'h7FFF);
    send_request(OP_ALLOC, 16'hFFFF);
    send_request(OP_FREE, 16'hFFFF);
  endtask

  task automatic test_random(int pct_idle, int chunks);
    int mem_pick[6];
    int r;
    int sz;
    mem_pick = '{1, 40, 64, 200, 1024, 16'hFFFF};
    idle_pct = pct_idle;
    for (int c = 0; c < chunks; c++) begin
      write_reg(REG_MEMORY_SIZE, ($urandom_range(0, 3) == 0) ?
                $urandom_range(1, 16'hFFFF) : mem_pick[$urandom_range(0, 5)]);
      write_reg(REG_FIT_POLICY, $urandom_range(0, 3));
      for (int i = 0; i < 64; i++) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          r = $urandom_range(0, 99);
          if (r < 3) sz = 0;
          else if (r < 6) sz = (mem_units < 16'hFFFF) ?
                              $urandom_range(mem_units + 1, 16'hFFFF) : mem_units;
          else if (r < 10) sz = $urandom_range(0, 16'hFFFF);
          else sz = $urandom_range(1, (mem_units / 6 > 1) ? mem_units / 6 : 1);
          send_request(OP_ALLOC, sz);
        end else begin
          sz = used_size_pick();
          if (sz < 0 || $urandom_range(0, 99) < 15) sz = $urandom_range(0, 16'hFFFF);
          send_request(OP_FREE, sz);
        end
      end
    end
  endtask

  initial begin
    mem_units = MEM_SIZE_RESET;
    policy = FIT_FIRST;
    comp_cnt = 0;
    table_init();
    repeat (2) @(negedge clk);
    rst = 1'b0;
    test_basic();
    test_full_table();
    test_policies();
    test_memory_extremes();
    test_random(29, 6);
    test_random(84, 6);
    test_random(0, 6);
    while (pending_results.size() != 0 && cycles < CYCLE_LIMIT) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("covered %0d requests and %0d results, %0d counted compactions",
             items_sent, results_seen, comp_cnt);
    $display("fit policies 0..3, memory sizes 1 to 65535, full table and waiting queue");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_variable_partition_allocator OK");
    end else begin
      $display("tb_variable_partition_allocator NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/vpa_pkg.sv
hdl/vpa_ctrl.sv
hdl/vpa_dp.sv
hdl/variable_partition_allocator.sv
tb/tb_variable_partition_allocator.sv
